// ----- rtl/ghsp_pkg.sv -----
// Shared types and constants for the generational handle slot pool.
// No dependencies; used by ghsp_gen_unit and generational_handle_slot_pool.
package ghsp_pkg;

  localparam int SLOTS = 64;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int GEN_W = 16;

  // Generations cycle through 1..GEN_MAX; zero is only the value before the first bump.
  localparam logic [GEN_W-1:0] GEN_MAX = '1;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef struct packed {
    logic             touched;
    logic             ever_cleared;
    logic [GEN_W-1:0] mem_ofs;
    logic [GEN_W-1:0] epoch;
  } gen_req_t;

  typedef struct packed {
    logic [GEN_W-1:0] cur_gen;
    logic [GEN_W-1:0] next_gen;
    logic [GEN_W-1:0] next_ofs;
  } gen_res_t;

endpackage

// ----- rtl/ghsp_gen_unit.sv -----
// Generation arithmetic: a slot stores an offset against the clear epoch.
// Depends on ghsp_pkg.
module ghsp_gen_unit (
  input  ghsp_pkg::gen_req_t req,
  output ghsp_pkg::gen_res_t res
);

  localparam logic [ghsp_pkg::GEN_W:0]   GEN_MOD     = {1'b0, ghsp_pkg::GEN_MAX};
  localparam logic [ghsp_pkg::GEN_W-1:0] OFS_FRESH   = ghsp_pkg::GEN_MAX - 16'd1;
  localparam logic [ghsp_pkg::GEN_W-1:0] ONE         = 16'd1;

  function automatic logic [ghsp_pkg::GEN_W-1:0] mod_add(
    input logic [ghsp_pkg::GEN_W-1:0] a,
    input logic [ghsp_pkg::GEN_W-1:0] b
  );
    logic [ghsp_pkg::GEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= GEN_MOD) begin
      s = s - GEN_MOD;
    end
    return s[ghsp_pkg::GEN_W-1:0];
  endfunction

  logic                       gen_nz;
  logic [ghsp_pkg::GEN_W-1:0] ofs_eff;
  logic [ghsp_pkg::GEN_W-1:0] ofs_new;

  always_comb begin
    gen_nz  = req.touched | req.ever_cleared;
    ofs_eff = req.touched ? req.mem_ofs : OFS_FRESH;
    if (!gen_nz) begin
      ofs_new = '0;
    end else if (ofs_eff == OFS_FRESH) begin
      ofs_new = '0;
    end else begin
      ofs_new = ofs_eff + ONE;
    end
    res.cur_gen  = gen_nz ? (mod_add(ofs_eff, req.epoch) + ONE) : '0;
    res.next_gen = mod_add(ofs_new, req.epoch) + ONE;
    res.next_ofs = ofs_new;
  end

endmodule

// ----- rtl/generational_handle_slot_pool.sv -----
// Top level of the generational handle slot pool: request pipeline, slot state, offset memory.
// Depends on ghsp_pkg and ghsp_gen_unit.
//
//   channel | dir | handshake              | payload
//   in_     | in  | in_tvalid / in_tready  | in_tdata: opcode, handle and owner fields
//   out_    | out | out_tvalid / out_tready| out_tdata: ok, slot_index, generation, count
//   cfg_    | in  | cfg_valid / cfg_ready  | cfg_data: owner_index_limit
//
// One request per cycle while in_tready is high; a taken request passes through the request
// register, the offset memory read and the result register before its result leaves.
// Reset (rst_n low, synchronous) empties the pool, zeroes every generation at once
// and sets owner_index_limit to 64; no sweep follows.
// A stall on out_tready holds the result register; the two stages behind it keep
// filling, so in_tready falls only once all three hold requests.
module generational_handle_slot_pool (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] opcode, [17:2] handle_index, [33:18] handle_generation,
  // [49:34] owner_index, [65:50] owner_generation, [71:66] zero
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] ok, [6:1] slot_index, [22:7] slot_generation, [29:23] active_slots, [31:30] zero
  output logic [31:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int IW = ghsp_pkg::IDX_W;
  localparam int CW = ghsp_pkg::CNT_W;
  localparam int GW = ghsp_pkg::GEN_W;
  localparam logic [GW-1:0] LIMIT_RST = 16'd64;
  localparam logic [GW-1:0] SLOTS_W   = GW'(ghsp_pkg::SLOTS);
  localparam logic [GW-1:0] EPOCH_TOP = ghsp_pkg::GEN_MAX - 16'd1;
  localparam logic [CW-1:0] CNT_ONE   = CW'(1);

  // slot state
  logic [ghsp_pkg::SLOTS-1:0] active_r, active_nxt;
  logic [ghsp_pkg::SLOTS-1:0] touched_r;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [GW-1:0]              epoch_r, epoch_nxt;
  logic                       ever_cleared_r;
  logic [GW-1:0]              limit_r;
  logic [GW-1:0]              ofs_mem [ghsp_pkg::SLOTS];

  // request stage
  logic          s1_v_r;
  ghsp_pkg::op_t s1_op_r;
  logic [GW-1:0] s1_hidx_r, s1_hgen_r, s1_oidx_r, s1_ogen_r;

  // memory read stage
  logic          s2_v_r;
  ghsp_pkg::op_t s2_op_r;
  logic [GW-1:0] s2_hidx_r, s2_hgen_r, s2_oidx_r, s2_ogen_r;
  logic [IW-1:0] s2_addr_r;
  logic          s2_anyfree_r;
  logic [GW-1:0] rd_data_r;
  logic          byp_r;
  logic [GW-1:0] byp_data_r;

  // result register
  logic          out_v_r;
  logic          out_ok_r;
  logic [IW-1:0] out_idx_r;
  logic [GW-1:0] out_gen_r;
  logic [CW-1:0] out_cnt_r;

  logic out_en, s2_en, s1_en, fire;
  logic [IW-1:0] free_idx, rd_addr;
  logic          any_free;
  logic          owner_ok, in_range, handle_ok, alloc_ok, free_ok, lookup_ok, mem_we;
  logic          res_ok;
  logic [IW-1:0] res_idx;
  logic [GW-1:0] res_gen;
  ghsp_pkg::gen_req_t gen_req;
  ghsp_pkg::gen_res_t gen_res;

  assign out_en    = !out_v_r || out_tready;
  assign s2_en     = !s2_v_r || out_en;
  assign s1_en     = !s1_v_r || s2_en;
  assign fire      = s2_v_r && out_en;
  assign in_tready = s1_en;
  assign cfg_ready = 1'b1;

  // generation of the slot in the read stage
  always_comb begin
    gen_req.touched      = touched_r[s2_addr_r];
    gen_req.ever_cleared = ever_cleared_r;
    gen_req.mem_ofs      = byp_r ? byp_data_r : rd_data_r;
    gen_req.epoch        = epoch_r;
  end

  ghsp_gen_unit u_gen (
    .req (gen_req),
    .res (gen_res)
  );

  always_comb begin
    owner_ok  = (s2_oidx_r < limit_r) && (s2_ogen_r != '0);
    in_range  = s2_hidx_r < SLOTS_W;
    handle_ok = in_range && active_r[s2_addr_r] && (gen_res.cur_gen == s2_hgen_r);
    alloc_ok  = (s2_op_r == ghsp_pkg::OP_ALLOC) && owner_ok && s2_anyfree_r;
    free_ok   = (s2_op_r == ghsp_pkg::OP_FREE) && handle_ok;
    lookup_ok = (s2_op_r == ghsp_pkg::OP_LOOKUP) && handle_ok;
    mem_we    = fire && (alloc_ok || free_ok);
  end

  // state after the read-stage request commits
  always_comb begin
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    epoch_nxt  = epoch_r;
    res_ok     = 1'b0;
    res_idx    = '0;
    res_gen    = '0;
    case (s2_op_r)
      ghsp_pkg::OP_ALLOC: begin
        if (alloc_ok) begin
          active_nxt[s2_addr_r] = 1'b1;
          cnt_nxt = cnt_r + CNT_ONE;
          res_ok  = 1'b1;
          res_idx = s2_addr_r;
          res_gen = gen_res.next_gen;
        end
      end
      ghsp_pkg::OP_FREE: begin
        if (free_ok) begin
          active_nxt[s2_addr_r] = 1'b0;
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - CNT_ONE;
          end
          res_ok  = 1'b1;
          res_idx = s2_addr_r;
        end
      end
      ghsp_pkg::OP_LOOKUP: begin
        if (lookup_ok) begin
          res_ok  = 1'b1;
          res_idx = s2_addr_r;
        end
      end
      ghsp_pkg::OP_CLEAR: begin
        active_nxt = '0;
        cnt_nxt    = '0;
        epoch_nxt  = (epoch_r == EPOCH_TOP) ? '0 : epoch_r + 16'd1;
        res_ok     = 1'b1;
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
    if (!fire) begin
      active_nxt = active_r;
      cnt_nxt    = cnt_r;
      epoch_nxt  = epoch_r;
    end
  end

  // lowest free slot, seen after the request ahead commits
  always_comb begin
    free_idx = '0;
    any_free = ~&active_nxt;
    for (int i = ghsp_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!active_nxt[i]) begin
        free_idx = IW'(i);
      end
    end
    rd_addr = (s1_op_r == ghsp_pkg::OP_ALLOC) ? free_idx : s1_hidx_r[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r       <= '0;
      touched_r      <= '0;
      cnt_r          <= '0;
      epoch_r        <= '0;
      ever_cleared_r <= 1'b0;
      limit_r        <= LIMIT_RST;
      s1_v_r         <= 1'b0;
      s2_v_r         <= 1'b0;
      out_v_r        <= 1'b0;
    end else begin
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
      epoch_r  <= epoch_nxt;
      if (mem_we) begin
        touched_r[s2_addr_r] <= 1'b1;
      end
      if (fire && (s2_op_r == ghsp_pkg::OP_CLEAR)) begin
        ever_cleared_r <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      if (s1_en) begin
        s1_v_r <= in_tvalid;
      end
      if (s2_en) begin
        s2_v_r <= s1_v_r;
      end
      if (out_en) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_op_r   <= ghsp_pkg::op_t'(in_tdata[1:0]);
      s1_hidx_r <= in_tdata[17:2];
      s1_hgen_r <= in_tdata[33:18];
      s1_oidx_r <= in_tdata[49:34];
      s1_ogen_r <= in_tdata[65:50];
    end
    if (s2_en) begin
      s2_op_r      <= s1_op_r;
      s2_hidx_r    <= s1_hidx_r;
      s2_hgen_r    <= s1_hgen_r;
      s2_oidx_r    <= s1_oidx_r;
      s2_ogen_r    <= s1_ogen_r;
      s2_addr_r    <= rd_addr;
      s2_anyfree_r <= any_free;
      byp_r        <= mem_we && (rd_addr == s2_addr_r);
      byp_data_r   <= gen_res.next_ofs;
    end
    if (out_en) begin
      out_ok_r  <= res_ok;
      out_idx_r <= res_idx;
      out_gen_r <= res_gen;
      out_cnt_r <= cnt_nxt;
    end
  end

  // offset memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ofs_mem[s2_addr_r] <= gen_res.next_ofs;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      rd_data_r <= ofs_mem[rd_addr];
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_cnt_r, out_gen_r, out_idx_r, out_ok_r};

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    32'($countones(active_r)) == 32'(cnt_r))
    else $error("occupancy count differs from active slots");

  a_epoch_range: assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r != ghsp_pkg::GEN_MAX)
    else $error("clear epoch out of range");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ok_r) |-> (out_idx_r == '0 && out_gen_r == '0))
    else $error("refused request carries slot fields");

  a_alloc_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && alloc_ok) |=> active_r[$past(s2_addr_r)])
    else $error("allocated slot not active");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for generational_handle_slot_pool: a directed table, then weighted random requests
// under several owner limits, checked against a behavioral model of the slot pool.
// Depends on ghsp_pkg and the RTL in rtl/.
module testbench;

  localparam int SLOTS = ghsp_pkg::SLOTS;
  localparam int IDX_W = ghsp_pkg::IDX_W;
  localparam int CNT_W = ghsp_pkg::CNT_W;
  localparam int GEN_W = ghsp_pkg::GEN_W;
  localparam logic [GEN_W-1:0] GEN_MAX = ghsp_pkg::GEN_MAX;

  localparam int DIRECTED_ROWS  = 24;
  localparam int STALL_PCT      = 33;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int REPORT_MAX     = 10;
  localparam int CLEAR_BURST    = 16;

  typedef struct packed {
    logic [15:0]   owner_gen;
    logic [15:0]   owner_index;
    logic [15:0]   handle_gen;
    logic [15:0]   handle_index;
    ghsp_pkg::op_t op;
  } pool_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] active_slots;
    logic [GEN_W-1:0] slot_gen;
    logic [IDX_W-1:0] slot_index;
    logic             ok;
  } pool_result_t;

  typedef struct {
    ghsp_pkg::op_t op;
    logic [15:0]   hidx;
    logic [15:0]   hgen;
    logic [15:0]   oidx;
    logic [15:0]   ogen;
    bit            fixed;
    logic          ok;
    logic [5:0]    sidx;
    logic [15:0]   sgen;
    logic [6:0]    cnt;
  } step_row_t;

  // op, hidx, hgen, oidx, ogen, fixed, ok, sidx, sgen, cnt
  step_row_t directed_steps [DIRECTED_ROWS] = '{
    '{ghsp_pkg::OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 0, 0, 16'h0000, 0},
    '{ghsp_pkg::OP_FREE,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 0, 0, 16'h0000, 0},
    '{ghsp_pkg::OP_ALLOC,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 0, 0, 16'h0000, 0},
    '{ghsp_pkg::OP_ALLOC,  16'h0000, 16'h0000, 16'h0040, 16'h0001, 1, 0, 0, 16'h0000, 0},
    '{ghsp_pkg::OP_ALLOC,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0, 0, 16'h0000, 0},
    '{ghsp_pkg::OP_ALLOC,  16'h0000, 16'h0000, 16'h003F, 16'hFFFF, 1, 1, 0, 16'h0001, 1},
    '{ghsp_pkg::OP_ALLOC,  16'h0000, 16'h0000, 16'h0000, 16'h0001, 1, 1, 1, 16'h0001, 2},
    '{ghsp_pkg::OP_LOOKUP, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 1, 1, 0, 16'h0000, 2},
    '{ghsp_pkg::OP_LOOKUP, 16'h0001, 16'h0002, 16'h0000, 16'h0000, 1, 0, 0, 16'h0000, 2},
    '{ghsp_pkg::OP_LOOKUP, 16'hFFFF, 16'h0001, 16'h0000, 16'h0000, 1, 0, 0, 16'h0000, 2},
    '{ghsp_pkg::OP_LOOKUP, 16'h0040, 16'h0001, 16'h0000, 16'h0000, 1, 0, 0, 16'h0000, 2},
    '{ghsp_pkg::OP_FREE,   16'h0040, 16'h0000, 16'h0000, 16'h0000, 1, 0, 0, 16'h0000, 2},
    '{ghsp_pkg::OP_FREE,   16'h0000, 16'h0001, 16'h0000, 16'h0000, 1, 1, 0, 16'h0000, 1},
    '{ghsp_pkg::OP_FREE,   16'h0000, 16'h0001, 16'h0000, 16'h0000, 1, 0, 0, 16'h0000, 1},
    '{ghsp_pkg::OP_LOOKUP, 16'h0000, 16'h0002, 16'h0000, 16'h0000, 1, 0, 0, 16'h0000, 1},
    '{ghsp_pkg::OP_ALLOC,  16'h0000, 16'h0000, 16'h0005, 16'h0007, 0, 0, 0, 16'h0000, 0},
    '{ghsp_pkg::OP_FREE,   16'h0001, 16'h0001, 16'h0000, 16'h0000, 0, 0, 0, 16'h0000, 0},
    '{ghsp_pkg::OP_CLEAR,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 0, 16'h0000, 0},
    '{ghsp_pkg::OP_LOOKUP, 16'h0000, 16'h0004, 16'h0000, 16'h0000, 1, 0, 0, 16'h0000, 0},
    '{ghsp_pkg::OP_ALLOC,  16'h0000, 16'h0000, 16'h0001, 16'h0001, 0, 0, 0, 16'h0000, 0},
    '{ghsp_pkg::OP_ALLOC,  16'h0000, 16'h0000, 16'h0002, 16'h8000, 0, 0, 0, 16'h0000, 0},
    '{ghsp_pkg::OP_LOOKUP, 16'h0001, 16'h0004, 16'h0000, 16'h0000, 0, 0, 0, 16'h0000, 0},
    '{ghsp_pkg::OP_LOOKUP, 16'h8001, 16'h0004, 16'h0000, 16'h0000, 1, 0, 0, 16'h0000, 2},
    '{ghsp_pkg::OP_FREE,   16'hFFC0, 16'h0000, 16'h0000, 16'h0000, 1, 0, 0, 16'h0000, 2}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data   = '0;

  logic             slot_live [SLOTS];
  logic [GEN_W-1:0] slot_gen  [SLOTS];
  int               live_count;
  logic [15:0]      owner_limit;

  pool_result_t pending_results [$];
  pool_result_t seen_result;
  pool_result_t due_result;
  bit           stall_en = 1'b1;
  int           requests_sent;
  int           results_checked;
  int           failures;
  int           idle_cycles;

  generational_handle_slot_pool uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= !stall_en || ($urandom_range(99) >= STALL_PCT);
  end

  function automatic logic [GEN_W-1:0] bump_gen(logic [GEN_W-1:0] g);
    return (g == GEN_MAX) ? 16'd1 : g + 16'd1;
  endfunction

  function automatic logic handle_live(logic [15:0] idx, logic [15:0] gen);
    if (idx >= SLOTS) return 1'b0;
    return slot_live[idx[IDX_W-1:0]] && (slot_gen[idx[IDX_W-1:0]] == gen);
  endfunction

  function automatic pool_result_t predict_pool_result(pool_req_t r);
    pool_result_t res;
    res = '0;
    case (r.op)
      ghsp_pkg::OP_ALLOC: begin
        if (r.owner_index < owner_limit && r.owner_gen != 16'd0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!slot_live[i] && !res.ok) begin
              slot_gen[i]    = bump_gen(slot_gen[i]);
              slot_live[i]   = 1'b1;
              live_count++;
              res.ok         = 1'b1;
              res.slot_index = IDX_W'(i);
              res.slot_gen   = slot_gen[i];
            end
          end
        end
      end
      ghsp_pkg::OP_FREE: begin
        if (handle_live(r.handle_index, r.handle_gen)) begin
          slot_gen[r.handle_index[IDX_W-1:0]]  = bump_gen(slot_gen[r.handle_index[IDX_W-1:0]]);
          slot_live[r.handle_index[IDX_W-1:0]] = 1'b0;
          if (live_count > 0) live_count--;
          res.ok         = 1'b1;
          res.slot_index = r.handle_index[IDX_W-1:0];
        end
      end
      ghsp_pkg::OP_LOOKUP: begin
        if (handle_live(r.handle_index, r.handle_gen)) begin
          res.ok         = 1'b1;
          res.slot_index = r.handle_index[IDX_W-1:0];
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) begin
          slot_gen[i]  = bump_gen(slot_gen[i]);
          slot_live[i] = 1'b0;
        end
        live_count = 0;
        res.ok     = 1'b1;
      end
    endcase
    res.active_slots = CNT_W'(live_count);
    return res;
  endfunction

  function automatic void report_field(string field, int unsigned want, int unsigned got);
    failures++;
    if (failures <= REPORT_MAX)
      $display("MISMATCH result %0d %s: expected 0x%0h, got 0x%0h",
               results_checked, field, want, got);
  endfunction

  task automatic issue_request(pool_req_t r, bit use_table, pool_result_t table_want);
    pool_result_t predicted;
    while (stall_en && $urandom_range(99) < STALL_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, r};
    do @(posedge clk); while (!in_tready);
    predicted = predict_pool_result(r);
    pending_results.push_back(use_table ? table_want : predicted);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic make_random_request(int alloc_pct, int clear_pct, output pool_req_t r);
    int pick;
    int live_slots [$];
    r.op           = ghsp_pkg::op_t'($urandom_range(3));
    r.handle_index = 16'($urandom);
    r.handle_gen   = 16'($urandom);
    r.owner_index  = 16'($urandom);
    r.owner_gen    = 16'($urandom);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_live[i]) live_slots.push_back(i);
    end
    pick = $urandom_range(99);
    if (pick < clear_pct) begin
      r.op = ghsp_pkg::OP_CLEAR;
    end else if (pick < clear_pct + alloc_pct) begin
      r.op = ghsp_pkg::OP_ALLOC;
      if ($urandom_range(9) == 0) begin
        if (owner_limit == 16'd0 || $urandom_range(1) == 0) r.owner_gen = '0;
        else r.owner_index = 16'($urandom_range(65535, owner_limit));
      end else begin
        r.owner_gen = 16'($urandom_range(65535, 1));
        if (owner_limit != 16'd0) r.owner_index = 16'($urandom_range(owner_limit - 1, 0));
      end
    end else if (pick < 85 && live_slots.size() != 0) begin
      r.op           = ($urandom_range(1) == 0) ? ghsp_pkg::OP_FREE : ghsp_pkg::OP_LOOKUP;
      r.handle_index = 16'(live_slots[$urandom_range(live_slots.size() - 1)]);
      r.handle_gen   = slot_gen[r.handle_index[IDX_W-1:0]];
      // stale handle
      if ($urandom_range(4) == 0) r.handle_gen = r.handle_gen - 16'd1;
    end else if (pick < 92) begin
      r.op = ($urandom_range(1) == 0) ? ghsp_pkg::OP_FREE : ghsp_pkg::OP_LOOKUP;
      if ($urandom_range(1) == 0) r.handle_index = 16'($urandom_range(65535, SLOTS));
      else r.handle_index = 16'($urandom_range(SLOTS - 1));
      if ($urandom_range(1) == 0) r.handle_gen = slot_gen[r.handle_index[IDX_W-1:0]];
    end else if (r.op == ghsp_pkg::OP_CLEAR && clear_pct == 0) begin
      r.op = ghsp_pkg::OP_LOOKUP;
    end
  endtask

  task automatic run_random(int count, int alloc_pct, int clear_pct);
    pool_req_t r;
    repeat (count) begin
      make_random_request(alloc_pct, clear_pct, r);
      issue_request(r, 1'b0, '0);
    end
  endtask

  task automatic write_owner_limit(logic [15:0] value);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    owner_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_result = out_tdata[29:0];
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("MISMATCH result %0d arrived with none outstanding: 0x%0h",
                   results_checked, seen_result);
      end else begin
        due_result = pending_results.pop_front();
        if (seen_result.ok != due_result.ok)
          report_field("ok", due_result.ok, seen_result.ok);
        if (seen_result.slot_index != due_result.slot_index)
          report_field("slot_index", due_result.slot_index, seen_result.slot_index);
        if (seen_result.slot_gen != due_result.slot_gen)
          report_field("slot_generation", due_result.slot_gen, seen_result.slot_gen);
        if (seen_result.active_slots != due_result.active_slots)
          report_field("active_slots", due_result.active_slots, seen_result.active_slots);
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    pool_req_t    r;
    pool_result_t want;
    for (int i = 0; i < SLOTS; i++) begin
      slot_live[i] = 1'b0;
      slot_gen[i]  = '0;
    end
    live_count  = 0;
    owner_limit = 16'd64;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < DIRECTED_ROWS; n++) begin
      r.op               = directed_steps[n].op;
      r.handle_index     = directed_steps[n].hidx;
      r.handle_gen       = directed_steps[n].hgen;
      r.owner_index      = directed_steps[n].oidx;
      r.owner_gen        = directed_steps[n].ogen;
      want.ok            = directed_steps[n].ok;
      want.slot_index    = directed_steps[n].sidx;
      want.slot_gen      = directed_steps[n].sgen;
      want.active_slots  = directed_steps[n].cnt;
      issue_request(r, directed_steps[n].fixed, want);
    end
    run_random(250, 40, 2);

    write_owner_limit(16'd0);
    run_random(80, 40, 1);

    write_owner_limit(16'd1);
    run_random(120, 45, 2);

    // fill the pool past capacity, then churn, all without stalls
    write_owner_limit(16'hFFFF);
    stall_en = 1'b0;
    repeat (SLOTS + 3) begin
      r             = '0;
      r.op          = ghsp_pkg::OP_ALLOC;
      r.handle_gen  = 16'($urandom);
      r.owner_index = 16'($urandom_range(65534));
      r.owner_gen   = 16'($urandom_range(65535, 1));
      issue_request(r, 1'b0, '0);
    end
    run_random(200, 30, 0);

    // back-to-back clears
    repeat (CLEAR_BURST) begin
      r              = '0;
      r.op           = ghsp_pkg::OP_CLEAR;
      r.handle_index = 16'($urandom);
      r.owner_gen    = 16'($urandom);
      issue_request(r, 1'b0, '0);
    end
    stall_en = 1'b1;

    write_owner_limit(16'($urandom_range(65535, 2)));
    run_random(200, 45, 4);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    failures += pending_results.size();

    $display("Checked %0d results for %0d requests: owner limits 64, 0, 1, 65535 and random,",
             results_checked, requests_sent);
    $display("pool full and empty, stale and out-of-range handles, a burst of %0d clears",
             CLEAR_BURST);
    if (failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
